// File: src/pld_pkg.sv
// Shared widths, register indexes and side-band types for the point-light
// diffuse shading pipeline. No dependencies; every other file imports it.
package pld_pkg;

  // Field and datapath widths
  localparam int POS_W     = 16;  // Q8.8 positions
  localparam int VEC_W     = 17;  // hit minus light
  localparam int NRM_W     = 16;  // Q1.14 normal
  localparam int COL_W     = 8;   // colour channel
  localparam int NUM_CHAN  = 3;
  localparam int SQ_W      = 33;  // one squared component
  localparam int DOT_W     = 33;  // one normal-by-vector product
  localparam int SUM_W     = 35;  // signed dot product sum
  localparam int LEN2_W    = 34;  // squared distance
  localparam int DIST_W    = LEN2_W / 2;
  localparam int NUM_W     = 33;  // positive cosine numerator
  localparam int ATT_W     = 16;
  localparam int LIN_W     = ATT_W + DIST_W;
  localparam int QUAD_W    = ATT_W + LEN2_W;
  localparam int DEN_W     = 51;
  localparam int PROD_W    = COL_W + NUM_W;
  localparam int FRAC_SH   = 10;
  localparam int SCALE_BITS = 8;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam logic [ATT_W-1:0] ATTEN_ONE = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X      = 3'd0,
    REG_LIGHT_Y      = 3'd1,
    REG_LIGHT_Z      = 3'd2,
    REG_CONST_ATTEN  = 3'd3,
    REG_LINEAR_ATTEN = 3'd4,
    REG_QUAD_ATTEN   = 3'd5
  } cfg_reg_t;

  // Carried alongside the square root
  typedef struct packed {
    logic                             black;
    logic [NUM_W-1:0]                 num;
    logic [LEN2_W-1:0]                len2;
    logic [NUM_CHAN-1:0][COL_W-1:0]   col;
  } root_sb_t;

  // Carried alongside the cosine divider
  typedef struct packed {
    logic                             black;
    logic [DEN_W-1:0]                 den;
    logic [NUM_CHAN-1:0][COL_W-1:0]   col;
  } div_sb_t;

  localparam int ROOT_SB_W = $bits(root_sb_t);
  localparam int DIV_SB_W  = $bits(div_sb_t);

endpackage

// File: src/pld_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on pld_pkg for default widths.
module pld_sqrt import pld_pkg::*; #(
  parameter int IN_W = LEN2_W,
  parameter int SB_W = ROOT_SB_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   rad_in,
  input  logic [SB_W-1:0]   sb_in,
  output logic              out_vld,
  output logic [IN_W/2-1:0] root_out,
  output logic [SB_W-1:0]   sb_out
);

  localparam int STEPS  = IN_W / 2;
  localparam int ROOT_W = STEPS;
  localparam int REM_W  = ROOT_W + 2;

  logic              vld  [STEPS];
  logic [REM_W-1:0]  rem  [STEPS];
  logic [ROOT_W-1:0] root [STEPS];
  logic [IN_W-1:0]   rad  [STEPS];
  logic [SB_W-1:0]   sb   [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic              pv;
    logic [REM_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    logic [IN_W-1:0]   prad;
    logic [SB_W-1:0]   psb;
    logic [REM_W+1:0]  r2;
    logic [REM_W+1:0]  trial;

    if (s == 0) begin : g_first
      assign pv    = in_vld;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = rad_in;
      assign psb   = sb_in;
    end else begin : g_next
      assign pv    = vld[s-1];
      assign prem  = rem[s-1];
      assign proot = root[s-1];
      assign prad  = rad[s-1];
      assign psb   = sb[s-1];
    end

    // bring down the next radicand pair and try the next root bit
    always_comb begin
      r2    = {prem, prad[IN_W-1 -: 2]};
      trial = {{(REM_W - ROOT_W){1'b0}}, proot, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= trial) begin
          rem[s]  <= REM_W'(r2 - trial);
          root[s] <= {proot[ROOT_W-2:0], 1'b1};
        end else begin
          rem[s]  <= r2[REM_W-1:0];
          root[s] <= {proot[ROOT_W-2:0], 1'b0};
        end
        rad[s] <= prad << 2;
        sb[s]  <= psb;
      end
    end
  end

  assign out_vld  = vld[STEPS-1];
  assign root_out = root[STEPS-1];
  assign sb_out   = sb[STEPS-1];

endmodule

// File: src/pld_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on pld_pkg for default widths.
module pld_div import pld_pkg::*; #(
  parameter int N_W  = NUM_W,
  parameter int D_W  = DIST_W,
  parameter int SB_W = DIV_SB_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [N_W-1:0]  dividend,
  input  logic [D_W-1:0]  divisor,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_vld,
  output logic [N_W-1:0]  quotient,
  output logic [SB_W-1:0] sb_out
);

  logic            vld [N_W];
  logic [D_W-1:0]  rem [N_W];
  logic [N_W-1:0]  quo [N_W];
  logic [N_W-1:0]  dvd [N_W];
  logic [D_W-1:0]  dvs [N_W];
  logic [SB_W-1:0] sb  [N_W];

  for (genvar s = 0; s < N_W; s++) begin : g_step
    logic            pv;
    logic [D_W-1:0]  prem;
    logic [N_W-1:0]  pquo;
    logic [N_W-1:0]  pdvd;
    logic [D_W-1:0]  pdvs;
    logic [SB_W-1:0] psb;
    logic [D_W:0]    r2;
    logic            fits;

    if (s == 0) begin : g_first
      assign pv   = in_vld;
      assign prem = '0;
      assign pquo = '0;
      assign pdvd = dividend;
      assign pdvs = divisor;
      assign psb  = sb_in;
    end else begin : g_next
      assign pv   = vld[s-1];
      assign prem = rem[s-1];
      assign pquo = quo[s-1];
      assign pdvd = dvd[s-1];
      assign pdvs = dvs[s-1];
      assign psb  = sb[s-1];
    end

    // shift in the next dividend bit and subtract where it fits
    always_comb begin
      r2   = {prem, pdvd[N_W-1]};
      fits = (r2 >= {1'b0, pdvs});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= fits ? D_W'(r2 - {1'b0, pdvs}) : r2[D_W-1:0];
        quo[s] <= {pquo[N_W-2:0], fits};
        dvd[s] <= pdvd << 1;
        dvs[s] <= pdvs;
        sb[s]  <= psb;
      end
    end
  end

  assign out_vld  = vld[N_W-1];
  assign quotient = quo[N_W-1];
  assign sb_out   = sb[N_W-1];

endmodule

// File: src/pld_scale.sv
// Final per-channel scale: (product << 10) / den clamped to 255, three lanes,
// one quotient bit per stage after a saturation check. Depends on pld_pkg.
module pld_scale import pld_pkg::*; (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic                              black,
  input  logic [DEN_W-1:0]                  den,
  input  logic [NUM_CHAN-1:0][PROD_W-1:0]   prod,
  output logic                              out_vld,
  output logic [NUM_CHAN-1:0][COL_W-1:0]    shade
);

  localparam int REM_W = PROD_W + FRAC_SH;
  localparam int CMP_W = DEN_W + SCALE_BITS + 1;

  // stage 0 is the saturation check, stages 1..SCALE_BITS make quotient bits
  logic                                  vld  [SCALE_BITS+1];
  logic                                  blk  [SCALE_BITS+1];
  logic [DEN_W-1:0]                      dn   [SCALE_BITS+1];
  logic [NUM_CHAN-1:0]                   sat  [SCALE_BITS+1];
  logic [NUM_CHAN-1:0][REM_W-1:0]        rem  [SCALE_BITS+1];
  logic [NUM_CHAN-1:0][SCALE_BITS-1:0]   quo  [SCALE_BITS+1];

  // saturation check: quotient of 256 or more clamps
  logic [NUM_CHAN-1:0][REM_W-1:0] rem0;
  logic [NUM_CHAN-1:0]            sat0;
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      rem0[c] = {prod[c], {FRAC_SH{1'b0}}};
      sat0[c] = (CMP_W'(rem0[c]) >= (CMP_W'(den) << SCALE_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk[0] <= black;
      dn[0]  <= den;
      sat[0] <= sat0;
      rem[0] <= rem0;
      quo[0] <= '0;
    end
  end

  for (genvar i = 1; i <= SCALE_BITS; i++) begin : g_bit
    localparam int B = SCALE_BITS - i;
    logic [NUM_CHAN-1:0][REM_W-1:0] rnext;
    logic [NUM_CHAN-1:0]            qbit;
    logic [CMP_W-1:0]               dsh;

    // subtract the shifted denominator where it fits
    always_comb begin
      dsh = CMP_W'(dn[i-1]) << B;
      for (int c = 0; c < NUM_CHAN; c++) begin
        qbit[c]  = (CMP_W'(rem[i-1][c]) >= dsh);
        rnext[c] = qbit[c] ? REM_W'(CMP_W'(rem[i-1][c]) - dsh) : rem[i-1][c];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        blk[i] <= blk[i-1];
        dn[i]  <= dn[i-1];
        sat[i] <= sat[i-1];
        rem[i] <= rnext;
        for (int c = 0; c < NUM_CHAN; c++) begin
          quo[i][c] <= {quo[i-1][c][SCALE_BITS-2:0], qbit[c]};
        end
      end
    end
  end

  // output register: black, clamp or quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[SCALE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (blk[SCALE_BITS]) begin
          shade[c] <= '0;
        end else if (sat[SCALE_BITS][c]) begin
          shade[c] <= '1;
        end else begin
          shade[c] <= quo[SCALE_BITS][c];
        end
      end
    end
  end

endmodule

// File: src/point_light_diffuse_shade.sv
// Lambert diffuse shading of one surface hit by a point light with distance
// attenuation. A fully pipelined datapath: one hit is taken every clock while
// the output is not stalled. Each hit passes the vector, product and sum
// registers, the 17-stage square root, the attenuation registers, the
// 33-stage cosine divider, the colour product register and the 9-stage
// channel scale with its output register. A stall on the output freezes the
// whole pipeline, so hit_stall follows shade_stall while a result waits.
// Light position and attenuation are written through cfg_write / cfg_index /
// cfg_data and must only change while no transaction is in flight.
// Depends on pld_pkg, pld_sqrt, pld_div and pld_scale.
module point_light_diffuse_shade import pld_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        hit_valid,
  output logic                        hit_stall,
  input  logic signed [POS_W-1:0]     hit_x,
  input  logic signed [POS_W-1:0]     hit_y,
  input  logic signed [POS_W-1:0]     hit_z,
  input  logic signed [NRM_W-1:0]     normal_x,
  input  logic signed [NRM_W-1:0]     normal_y,
  input  logic signed [NRM_W-1:0]     normal_z,
  input  logic [COL_W-1:0]            diffuse_red,
  input  logic [COL_W-1:0]            diffuse_green,
  input  logic [COL_W-1:0]            diffuse_blue,
  output logic                        shade_valid,
  input  logic                        shade_stall,
  output logic [COL_W-1:0]            shade_red,
  output logic [COL_W-1:0]            shade_green,
  output logic [COL_W-1:0]            shade_blue
);

  // configuration registers
  logic signed [POS_W-1:0] light_x;
  logic signed [POS_W-1:0] light_y;
  logic signed [POS_W-1:0] light_z;
  logic [ATT_W-1:0]        const_atten;
  logic [ATT_W-1:0]        linear_atten;
  logic [ATT_W-1:0]        quad_atten;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x      <= '0;
      light_y      <= '0;
      light_z      <= '0;
      const_atten  <= ATTEN_ONE;
      linear_atten <= '0;
      quad_atten   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LIGHT_X:      light_x      <= cfg_data;
        REG_LIGHT_Y:      light_y      <= cfg_data;
        REG_LIGHT_Z:      light_z      <= cfg_data;
        REG_CONST_ATTEN:  const_atten  <= cfg_data;
        REG_LINEAR_ATTEN: linear_atten <= cfg_data;
        REG_QUAD_ATTEN:   quad_atten   <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output is held
  logic adv;
  assign adv       = !(shade_valid && shade_stall);
  assign hit_stall = shade_valid && shade_stall;

  // stage 1: light-to-hit vector
  logic                            vld1;
  logic signed [VEC_W-1:0]         vx1, vy1, vz1;
  logic signed [NRM_W-1:0]         nx1, ny1, nz1;
  logic [NUM_CHAN-1:0][COL_W-1:0]  col1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv) begin
      vld1 <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx1  <= VEC_W'(hit_x) - VEC_W'(light_x);
      vy1  <= VEC_W'(hit_y) - VEC_W'(light_y);
      vz1  <= VEC_W'(hit_z) - VEC_W'(light_z);
      nx1  <= normal_x;
      ny1  <= normal_y;
      nz1  <= normal_z;
      col1 <= {diffuse_blue, diffuse_green, diffuse_red};
    end
  end

  // stage 2: squares and normal products
  logic                            vld2;
  logic [SQ_W-1:0]                 sqx2, sqy2, sqz2;
  logic signed [DOT_W-1:0]         dpx2, dpy2, dpz2;
  logic [NUM_CHAN-1:0][COL_W-1:0]  col2;
  logic signed [2*VEC_W-1:0]       sqx, sqy, sqz;

  always_comb begin
    sqx = vx1 * vx1;
    sqy = vy1 * vy1;
    sqz = vz1 * vz1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx2 <= sqx[SQ_W-1:0];
      sqy2 <= sqy[SQ_W-1:0];
      sqz2 <= sqz[SQ_W-1:0];
      dpx2 <= nx1 * vx1;
      dpy2 <= ny1 * vy1;
      dpz2 <= nz1 * vz1;
      col2 <= col1;
    end
  end

  // stage 3: squared length, cosine numerator, black flag
  logic                     vld3;
  root_sb_t                 sb3;
  logic [LEN2_W-1:0]        len2;
  logic signed [SUM_W-1:0]  dsum;
  logic signed [SUM_W-1:0]  nsum;

  always_comb begin
    len2 = LEN2_W'(sqx2) + LEN2_W'(sqy2) + LEN2_W'(sqz2);
    dsum = SUM_W'(dpx2) + SUM_W'(dpy2) + SUM_W'(dpz2);
    nsum = -dsum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (adv) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb3.black <= (len2 == '0) || nsum[SUM_W-1] || (nsum == '0);
      sb3.num   <= nsum[NUM_W-1:0];
      sb3.len2  <= len2;
      sb3.col   <= col2;
    end
  end

  // distance
  logic              vld_r;
  logic [DIST_W-1:0] dist_r;
  root_sb_t          sb_r;

  pld_sqrt #(
    .IN_W (LEN2_W),
    .SB_W (ROOT_SB_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vld3),
    .rad_in   (sb3.len2),
    .sb_in    (sb3),
    .out_vld  (vld_r),
    .root_out (dist_r),
    .sb_out   (sb_r)
  );

  // stage A: attenuation products
  logic                            vld_a;
  logic [LIN_W-1:0]                lin_a;
  logic [QUAD_W-1:0]               quad_a;
  logic [DIST_W-1:0]               dist_a;
  logic [NUM_W-1:0]                num_a;
  logic                            blk_a;
  logic [NUM_CHAN-1:0][COL_W-1:0]  col_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (adv) begin
      vld_a <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_a  <= linear_atten * dist_r;
      quad_a <= quad_atten * sb_r.len2;
      dist_a <= dist_r;
      num_a  <= sb_r.num;
      blk_a  <= sb_r.black;
      col_a  <= sb_r.col;
    end
  end

  // stage B: denominator, all-zero attenuation taken as 1.0
  logic              vld_b;
  div_sb_t           sb_b;
  logic [DIST_W-1:0] dist_b;
  logic [NUM_W-1:0]  num_b;
  logic              atten_zero;

  assign atten_zero = (const_atten == '0) && (linear_atten == '0) && (quad_atten == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (adv) begin
      vld_b <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (atten_zero) begin
        sb_b.den <= DEN_W'({ATTEN_ONE, 16'b0});
      end else begin
        sb_b.den <= DEN_W'({const_atten, 16'b0}) + DEN_W'({lin_a, 8'b0})
                    + DEN_W'(quad_a);
      end
      sb_b.black <= blk_a;
      sb_b.col   <= col_a;
      dist_b     <= dist_a;
      num_b      <= num_a;
    end
  end

  // cosine = numerator / distance
  logic             vld_c;
  logic [NUM_W-1:0] cosq_c;
  div_sb_t          sb_c;

  pld_div #(
    .N_W  (NUM_W),
    .D_W  (DIST_W),
    .SB_W (DIV_SB_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vld_b),
    .dividend (num_b),
    .divisor  (dist_b),
    .sb_in    (sb_b),
    .out_vld  (vld_c),
    .quotient (cosq_c),
    .sb_out   (sb_c)
  );

  // stage P: colour times cosine
  logic                             vld_p;
  logic                             blk_p;
  logic [DEN_W-1:0]                 den_p;
  logic [NUM_CHAN-1:0][PROD_W-1:0]  prod_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (adv) begin
      vld_p <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blk_p <= sb_c.black;
      den_p <= sb_c.den;
      for (int c = 0; c < NUM_CHAN; c++) begin
        prod_p[c] <= sb_c.col[c] * cosq_c;
      end
    end
  end

  // attenuate and clamp
  logic [NUM_CHAN-1:0][COL_W-1:0] shade;

  pld_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (vld_p),
    .black   (blk_p),
    .den     (den_p),
    .prod    (prod_p),
    .out_vld (shade_valid),
    .shade   (shade)
  );

  assign shade_red   = shade[0];
  assign shade_green = shade[1];
  assign shade_blue  = shade[2];

endmodule

// File: src/pld_checker.sv
// Port-level checks for point_light_diffuse_shade, attached by bind.
// Depends on pld_pkg for widths.
module pld_checker import pld_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               hit_stall,
  input logic               shade_valid,
  input logic               shade_stall,
  input logic [COL_W-1:0]   shade_red,
  input logic [COL_W-1:0]   shade_green,
  input logic [COL_W-1:0]   shade_blue
);

  // input is held back only while a finished result waits
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    hit_stall |-> (shade_valid && shade_stall))
    else $error("hit_stall raised without a stalled result");

  // nothing leaves straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !shade_valid)
    else $error("result shown right after reset");

  // a stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (shade_valid && shade_stall) |=> shade_valid)
    else $error("stalled result dropped");

  // a stalled result keeps its colour
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (shade_valid && shade_stall) |=>
      ($stable(shade_red) && $stable(shade_green) && $stable(shade_blue)))
    else $error("stalled result changed");

endmodule

bind point_light_diffuse_shade pld_checker u_pld_checker (
  .clk         (clk),
  .rst         (rst),
  .hit_stall   (hit_stall),
  .shade_valid (shade_valid),
  .shade_stall (shade_stall),
  .shade_red   (shade_red),
  .shade_green (shade_green),
  .shade_blue  (shade_blue)
);

// File: tb/sv/tb_point_light_diffuse_shade.sv
// Testbench for point_light_diffuse_shade: drives hits with random idling and
// output stalls, predicts each shaded colour and checks results in order.
// Depends on pld_pkg and the point_light_diffuse_shade RTL.
`timescale 1ns / 1ps

module tb_point_light_diffuse_shade;
  import pld_pkg::*;

  typedef struct {
    logic signed [15:0] hx, hy, hz, nx, ny, nz;
    logic [7:0] cr, cg, cb;
  } hit_t;

  typedef struct {
    logic [7:0] r, g, b;
  } colour_t;

  // Expected shades, predicted from the light registers
  class shade_scoreboard;
    logic signed [15:0] lx, ly, lz;
    logic [15:0] catt, latt, qatt;
    colour_t pending[$];
    int errors;

    function void reset_regs();
      lx = '0; ly = '0; lz = '0; catt = ATTEN_ONE; latt = '0; qatt = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_LIGHT_X: lx = val;
        REG_LIGHT_Y: ly = val;
        REG_LIGHT_Z: lz = val;
        REG_CONST_ATTEN: catt = val;
        REG_LINEAR_ATTEN: latt = val;
        REG_QUAD_ATTEN: qatt = val;
        default: ;
      endcase
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= root + b) begin
          n -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    function void note_hit(hit_t h);
      longint vx, vy, vz, num;
      longint unsigned len2, dlen, cosq, den, v;
      logic [7:0] ch[3];
      colour_t c;
      vx = longint'(h.hx) - longint'(lx);
      vy = longint'(h.hy) - longint'(ly);
      vz = longint'(h.hz) - longint'(lz);
      ch[0] = h.cr; ch[1] = h.cg; ch[2] = h.cb;
      c.r = '0; c.g = '0; c.b = '0;
      len2 = vx * vx + vy * vy + vz * vz;
      num = -(longint'(h.nx) * vx + longint'(h.ny) * vy + longint'(h.nz) * vz);
      // Zero distance and facing away both give black
      if (len2 != 0 && num > 0) begin
        dlen = int_sqrt(len2);
        cosq = longint'(num) / dlen;
        den = (longint'(catt) << 16) + ((longint'(latt) * dlen) << 8)
              + longint'(qatt) * len2;
        if (catt == 0 && latt == 0 && qatt == 0) den = 64'd1 << 24;
        for (int k = 0; k < 3; k++) begin
          v = ((longint'(ch[k]) * cosq) << 10) / den;
          ch[k] = (v > 255) ? 8'd255 : v[7:0];
        end
        c.r = ch[0]; c.g = ch[1]; c.b = ch[2];
      end
      pending.push_back(c);
    endfunction

    function void check_shade(colour_t got);
      colour_t exp_c;
      if (pending.size() == 0) begin
        $display("%0t: unexpected shade %h %h %h", $time, got.r, got.g, got.b);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got.r !== exp_c.r) begin
        $display("%0t: red expected %0d actual %0d", $time, exp_c.r, got.r);
        errors++;
      end
      if (got.g !== exp_c.g) begin
        $display("%0t: green expected %0d actual %0d", $time, exp_c.g, got.g);
        errors++;
      end
      if (got.b !== exp_c.b) begin
        $display("%0t: blue expected %0d actual %0d", $time, exp_c.b, got.b);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  logic hit_valid = 0, hit_stall;
  logic signed [15:0] hit_x = 0, hit_y = 0, hit_z = 0;
  logic signed [15:0] normal_x = 0, normal_y = 0, normal_z = 0;
  logic [7:0] diffuse_red = 0, diffuse_green = 0, diffuse_blue = 0;
  logic shade_valid, shade_stall = 1;
  logic [7:0] shade_red, shade_green, shade_blue;

  shade_scoreboard sb;
  int cycles = 0;
  bit calm = 0;       // stretch with no idling on either side
  bit hold_off = 0;   // request a long output stall

  localparam int CYCLE_LIMIT = 400000;
  // index past the last register, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 3'd7;

  point_light_diffuse_shade dut (.*);

  always #2 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check each accepted shade
  always @(posedge clk) begin
    colour_t c;
    if (!rst && shade_valid && !shade_stall) begin
      c.r = shade_red; c.g = shade_green; c.b = shade_blue;
      sb.check_shade(c);
    end
  end

  // Receiver: random stalls, with a long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    shade_stall <= 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        shade_stall <= 1;
        for (n = 0; n < 300; n++) @(negedge clk);
        hold_off = 0;
        shade_stall <= 0;
      end else begin
        shade_stall <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  // One write, then cfg_write is dropped and the port idles before the task returns
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_write <= 0;
    @(negedge clk);
  endtask

  // Offer one hit and hold it until accepted
  task automatic send_hit(hit_t h);
    while (!calm && $urandom_range(99) < 7) begin
      hit_valid <= 0;
      @(negedge clk);
    end
    hit_valid <= 1;
    hit_x <= h.hx; hit_y <= h.hy; hit_z <= h.hz;
    normal_x <= h.nx; normal_y <= h.ny; normal_z <= h.nz;
    diffuse_red <= h.cr; diffuse_green <= h.cg; diffuse_blue <= h.cb;
    @(posedge clk);
    while (hit_stall) @(posedge clk);
    sb.note_hit(h);
    @(negedge clk);
  endtask

  task automatic drain();
    hit_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic hit_t random_hit();
    hit_t h;
    int s;
    s = $urandom_range(3);
    // Mostly hits near the light with unit-ish normals, sometimes full range
    if (s == 0) begin
      h.hx = 16'($urandom); h.hy = 16'($urandom); h.hz = 16'($urandom);
      h.nx = 16'($urandom); h.ny = 16'($urandom); h.nz = 16'($urandom);
    end else begin
      h.hx = 16'(sb.lx + $signed(16'($urandom_range(2047))) - 1024);
      h.hy = 16'(sb.ly + $signed(16'($urandom_range(2047))) - 1024);
      h.hz = 16'(sb.lz + $signed(16'($urandom_range(2047))) - 1024);
      h.nx = 16'($signed(16'($urandom_range(32768))) - 16384);
      h.ny = 16'($signed(16'($urandom_range(32768))) - 16384);
      h.nz = 16'($signed(16'($urandom_range(32768))) - 16384);
    end
    h.cr = 8'($urandom); h.cg = 8'($urandom); h.cb = 8'($urandom);
    return h;
  endfunction

  function automatic hit_t make_hit(int x, int y, int z, int nx, int ny, int nz,
                                    int r, int g, int b);
    hit_t h;
    h.hx = 16'(x); h.hy = 16'(y); h.hz = 16'(z);
    h.nx = 16'(nx); h.ny = 16'(ny); h.nz = 16'(nz);
    h.cr = 8'(r); h.cg = 8'(g); h.cb = 8'(b);
    return h;
  endfunction

  // Stimulus
  initial begin
    logic [15:0] att_pick[4];
    sb = new();
    sb.reset_regs();
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: reset registers
    send_hit(make_hit(0, 0, 0, 16384, 0, 0, 255, 255, 255));      // zero distance
    send_hit(make_hit(256, 0, 0, -16384, 0, 0, 255, 128, 1));     // head on
    send_hit(make_hit(256, 0, 0, 16384, 0, 0, 255, 255, 255));    // facing away
    send_hit(make_hit(0, 512, 0, 0, -32768, 0, 255, 200, 7));     // non-unit normal
    send_hit(make_hit(-32768, -32768, -32768, 32767, 32767, 32767, 255, 255, 255));
    send_hit(make_hit(32767, 32767, 32767, -32768, -32768, -32768, 0, 255, 128));
    send_hit(make_hit(64, 0, 0, -16384, 0, 0, 255, 255, 255));    // close: just reaches 255
    drain();

    // Extreme light and all attenuation zero
    write_reg(REG_LIGHT_X, 16'h8000);
    write_reg(REG_LIGHT_Y, 16'h7fff);
    write_reg(REG_LIGHT_Z, 16'h8000);
    write_reg(REG_CONST_ATTEN, 16'h0000);
    write_reg(REG_LINEAR_ATTEN, 16'h0000);
    write_reg(REG_QUAD_ATTEN, 16'h0000);
    send_hit(make_hit(32767, -32768, 32767, -16384, 16384, -16384, 255, 255, 255));
    send_hit(make_hit(-32768, 32767, -32768, 0, 0, 0, 255, 255, 255));
    send_hit(make_hit(-32767, 32767, -32768, -16384, 0, 0, 255, 9, 99));
    drain();
    write_reg(REG_CONST_ATTEN, 16'hffff);
    write_reg(REG_LINEAR_ATTEN, 16'hffff);
    write_reg(REG_QUAD_ATTEN, 16'hffff);
    send_hit(make_hit(32767, -32768, 32767, -16384, 16384, -16384, 255, 255, 255));
    send_hit(make_hit(-32000, 32767, -32768, -16384, 0, 0, 255, 255, 255));
    drain();
    // Ignored register index
    cfg_write <= 1; cfg_index <= IDX_UNMAPPED; cfg_data <= 16'h1234;
    @(negedge clk);
    cfg_write <= 0;
    send_hit(make_hit(-32000, 32767, -32768, -16384, 0, 0, 255, 255, 255));
    drain();

    // Random phases over several register settings
    att_pick[0] = 16'd0; att_pick[1] = 16'hffff; att_pick[2] = 16'd256;
    att_pick[3] = 16'd16;
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(REG_LIGHT_X, 16'($urandom));
      write_reg(REG_LIGHT_Y, 16'($urandom));
      write_reg(REG_LIGHT_Z, 16'($urandom));
      write_reg(REG_CONST_ATTEN, $urandom_range(1) ? att_pick[$urandom_range(3)]
                                                  : 16'($urandom));
      write_reg(REG_LINEAR_ATTEN, $urandom_range(1) ? att_pick[$urandom_range(3)]
                                                   : 16'($urandom_range(64)));
      write_reg(REG_QUAD_ATTEN, $urandom_range(1) ? att_pick[$urandom_range(3)]
                                                 : 16'($urandom_range(16)));
      calm = (ph == 3);
      if (ph == 5) hold_off = 1;
      for (int i = 0; i < 150; i++) send_hit(random_hit());
      calm = 0;
      drain();
    end

    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/pld_pkg.sv
src/pld_sqrt.sv
src/pld_div.sv
src/pld_scale.sv
src/point_light_diffuse_shade.sv
src/pld_checker.sv
tb/sv/tb_point_light_diffuse_shade.sv
